FILE: hdl/wlrs_pkg.sv
`default_nettype none
package wlrs_pkg;

    localparam int STORE_BYTES  = 1024;
    localparam int RECORD_BYTES = 16;
    localparam int SLOTS        = STORE_BYTES / RECORD_BYTES;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int OFF_W        = $clog2(RECORD_BYTES);
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int CNT_W        = SLOT_W + 1;

    // bytes covered by the check sum, and where the check byte sits
    localparam int SUM_BYTES    = 12;
    localparam int CHK_OFF      = RECORD_BYTES - 1;
    localparam int BI_W         = 4;

    localparam logic [15:0] DEF_MIN = 16'd554;
    localparam logic [15:0] DEF_MAX = 16'd916;
    localparam logic [15:0] DEF_SET = 16'd629;
    localparam logic [7:0]  MAX_OFF = 8'd30;

    typedef enum logic [2:0] {
        ACT_MOUNT     = 3'd0,
        ACT_LOAD      = 3'd1,
        ACT_SAVE_TEMP = 3'd2,
        ACT_SAVE_SET  = 3'd3,
        ACT_SAVE_CAL  = 3'd4,
        ACT_DEFAULTS  = 3'd5
    } t_action;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(SLOTS - 1)) begin
            r = '0;
        end else begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/wlrs_ram.sv
`default_nettype none
module wlrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

FILE: hdl/wear_leveled_record_store_core.sv
// mount scans slots up to the first bad record; load reads the read slot; a save writes one
// record; a skipped save, a save before mount, defaults without write-back or a bad code
// write nothing; one item at a time; the single byte port of the record ram sets the pace
// reset: control, pointers and working copy return to defaults, and a valid
// bit per slot clears so the whole ring reads as erased at once
// results come as a one-cycle o_valid strobe; the receiver cannot stall
`default_nettype none
module wear_leveled_record_store_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [15:0] i_new_temp,
    input  wire logic [15:0] i_new_temp_min,
    input  wire logic [15:0] i_new_temp_max,
    input  wire logic [7:0]  i_new_off_timeout,
    input  wire logic        i_new_celsius,
    input  wire logic        i_write_back,
    output logic             o_valid,
    output logic             o_done_ok,
    output logic             o_record_valid,
    output logic [15:0]      o_cur_temp,
    output logic [15:0]      o_cur_temp_min,
    output logic [15:0]      o_cur_temp_max,
    output logic [7:0]       o_cur_off_timeout,
    output logic             o_cur_celsius,
    output logic [31:0]      o_record_id
);

    localparam int SW = wlrs_pkg::SLOT_W;
    localparam int BW = wlrs_pkg::BI_W;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_MFIN, S_WR, S_DONE} t_state;

    t_state           r_state;
    logic             r_is_mount;
    logic [BW-1:0]    r_bi;
    logic [7:0]       r_sum;
    logic             r_good;
    logic [7:0]       r_buf [wlrs_pkg::SUM_BYTES];
    logic [SW-1:0]    r_slot;
    logic [SW-1:0]    r_rp;
    logic [SW-1:0]    r_wp;
    logic [wlrs_pkg::CNT_W-1:0] r_count;
    logic [31:0]      r_min_id, r_max_id;
    logic [SW-1:0]    r_min_slot, r_max_slot;
    logic [31:0]      r_next;
    logic [31:0]      r_wseq;
    logic             r_writable;
    logic             r_loaded;
    logic             r_ok;
    logic [wlrs_pkg::SLOTS-1:0] r_slot_vld;
    logic [15:0]      r_temp, r_tmin, r_tmax;
    logic [7:0]       r_off, r_cel;

    logic                        ram_we;
    logic [wlrs_pkg::ADDR_W-1:0] ram_addr;
    logic [7:0]                  ram_wdata, ram_rdata;
    logic [wlrs_pkg::OFF_W-1:0]  off;
    logic [7:0]                  cap;
    logic [BW-1:0]               cap_idx;
    logic [7:0]                  wr_bytes [wlrs_pkg::SUM_BYTES];
    logic [31:0]                 buf_seq;
    logic [15:0]                 b_tmin, b_tmax, b_temp, f_tmin, f_tmax, f_temp;
    logic [7:0]                  b_off, b_cel, f_off, f_cel;
    logic [31:0]                 save_seq;

    wlrs_ram #(.WIDTH(8), .DEPTH(wlrs_pkg::STORE_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        off = (r_bi == BW'(wlrs_pkg::SUM_BYTES)) ? wlrs_pkg::OFF_W'(wlrs_pkg::CHK_OFF)
                                                 : wlrs_pkg::OFF_W'(r_bi);
        ram_addr = wlrs_pkg::ADDR_W'({(r_state == S_WR) ? r_wp : r_slot, off});
        ram_we   = (r_state == S_WR);
        wr_bytes[0]  = r_wseq[7:0];
        wr_bytes[1]  = r_wseq[15:8];
        wr_bytes[2]  = r_wseq[23:16];
        wr_bytes[3]  = r_wseq[31:24];
        wr_bytes[4]  = r_tmin[7:0];
        wr_bytes[5]  = r_tmin[15:8];
        wr_bytes[6]  = r_tmax[7:0];
        wr_bytes[7]  = r_tmax[15:8];
        wr_bytes[8]  = r_temp[7:0];
        wr_bytes[9]  = r_temp[15:8];
        wr_bytes[10] = r_off;
        wr_bytes[11] = r_cel;
        ram_wdata = (r_bi < BW'(wlrs_pkg::SUM_BYTES)) ? wr_bytes[r_bi] : r_sum + 8'd1;
        // a slot never written reads as erased
        cap     = r_slot_vld[r_slot] ? ram_rdata : 8'hFF;
        cap_idx = r_bi - BW'(1);
    end

    // payload of the captured slot and the load repairs
    always_comb begin
        buf_seq = {r_buf[3], r_buf[2], r_buf[1], r_buf[0]};
        b_tmin  = {r_buf[5], r_buf[4]};
        b_tmax  = {r_buf[7], r_buf[6]};
        b_temp  = {r_buf[9], r_buf[8]};
        b_off   = r_buf[10];
        b_cel   = r_buf[11];
        f_tmin = b_tmin;
        f_tmax = b_tmax;
        f_temp = b_temp;
        f_off  = b_off;
        f_cel  = b_cel;
        if (b_tmin >= b_tmax) begin
            f_tmin = wlrs_pkg::DEF_MIN;
            f_tmax = wlrs_pkg::DEF_MAX;
            f_temp = wlrs_pkg::DEF_SET;
            f_off  = 8'd0;
            f_cel  = 8'd1;
        end
        if (f_temp > f_tmax || f_temp < f_tmin) begin
            f_temp = wlrs_pkg::DEF_SET;
        end
        if (f_off > wlrs_pkg::MAX_OFF) begin
            f_off = 8'd0;
        end
        save_seq = (r_next == 32'd0) ? 32'd1 : r_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_is_mount <= 1'b0;
            r_bi       <= '0;
            r_rp       <= '0;
            r_wp       <= '0;
            r_next     <= '0;
            r_writable <= 1'b0;
            r_loaded   <= 1'b0;
            r_ok       <= 1'b0;
            r_slot_vld <= '0;
            r_temp     <= wlrs_pkg::DEF_SET;
            r_tmin     <= wlrs_pkg::DEF_MIN;
            r_tmax     <= wlrs_pkg::DEF_MAX;
            r_off      <= 8'd0;
            r_cel      <= 8'd1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_bi  <= '0;
                        r_sum <= '0;
                        r_ok  <= 1'b1;
                        r_state <= S_DONE;
                        unique case (i_action)
                            wlrs_pkg::ACT_MOUNT: begin
                                r_temp <= wlrs_pkg::DEF_SET;
                                r_tmin <= wlrs_pkg::DEF_MIN;
                                r_tmax <= wlrs_pkg::DEF_MAX;
                                r_off  <= 8'd0;
                                r_cel  <= 8'd1;
                                r_next <= '0;
                                r_count    <= '0;
                                r_min_id   <= 32'hFFFF_FFFF;
                                r_max_id   <= '0;
                                r_min_slot <= '0;
                                r_max_slot <= '0;
                                r_slot     <= '0;
                                r_is_mount <= 1'b1;
                                r_state    <= S_RD;
                            end
                            wlrs_pkg::ACT_LOAD: begin
                                r_slot     <= r_rp;
                                r_is_mount <= 1'b0;
                                r_state    <= S_RD;
                            end
                            wlrs_pkg::ACT_SAVE_TEMP: begin
                                if (i_new_temp != r_temp) begin
                                    r_temp  <= i_new_temp;
                                    r_ok    <= 1'b0;
                                    r_wseq  <= save_seq;
                                    r_state <= r_writable ? S_WR : S_DONE;
                                end
                            end
                            wlrs_pkg::ACT_SAVE_SET: begin
                                r_off   <= (i_new_off_timeout > wlrs_pkg::MAX_OFF) ? 8'd0
                                                                                   : i_new_off_timeout;
                                r_cel   <= {7'd0, i_new_celsius};
                                r_ok    <= 1'b0;
                                r_wseq  <= save_seq;
                                r_state <= r_writable ? S_WR : S_DONE;
                            end
                            wlrs_pkg::ACT_SAVE_CAL: begin
                                r_tmin  <= i_new_temp_min;
                                r_tmax  <= i_new_temp_max;
                                r_ok    <= 1'b0;
                                r_wseq  <= save_seq;
                                r_state <= r_writable ? S_WR : S_DONE;
                            end
                            wlrs_pkg::ACT_DEFAULTS: begin
                                r_temp <= wlrs_pkg::DEF_SET;
                                r_tmin <= wlrs_pkg::DEF_MIN;
                                r_tmax <= wlrs_pkg::DEF_MAX;
                                r_off  <= 8'd0;
                                r_cel  <= 8'd1;
                                if (i_write_back) begin
                                    r_ok    <= 1'b0;
                                    r_wseq  <= save_seq;
                                    r_state <= r_writable ? S_WR : S_DONE;
                                end
                            end
                            default: r_ok <= 1'b0;
                        endcase
                    end
                end
                S_RD: begin
                    // reads issue one byte ahead of the capture
                    r_bi <= r_bi + BW'(1);
                    if (r_bi != '0) begin
                        if (cap_idx < BW'(wlrs_pkg::SUM_BYTES)) begin
                            r_buf[cap_idx] <= cap;
                            r_sum <= {r_sum[5:0], 2'b00} + cap;
                        end else begin
                            r_good  <= (r_sum + 8'd1 == cap);
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_bi  <= '0;
                    r_sum <= '0;
                    if (r_is_mount) begin
                        r_state <= S_MFIN;
                        if (r_good) begin
                            r_tmin  <= b_tmin;
                            r_tmax  <= b_tmax;
                            r_temp  <= b_temp;
                            r_off   <= b_off;
                            r_cel   <= b_cel;
                            r_count <= r_count + wlrs_pkg::CNT_W'(1);
                            if (r_min_id > buf_seq) begin
                                r_min_id   <= buf_seq;
                                r_min_slot <= r_slot;
                            end
                            if (r_max_id < buf_seq) begin
                                r_max_id   <= buf_seq;
                                r_max_slot <= r_slot;
                            end
                            if (r_slot != SW'(wlrs_pkg::SLOTS - 1)) begin
                                r_slot  <= r_slot + SW'(1);
                                r_state <= S_RD;
                            end
                        end
                    end else begin
                        r_loaded <= r_good;
                        r_ok     <= r_good;
                        r_state  <= S_DONE;
                        if (r_good) begin
                            r_next <= buf_seq + 32'd1;
                            r_tmin <= f_tmin;
                            r_tmax <= f_tmax;
                            r_temp <= f_temp;
                            r_off  <= f_off;
                            r_cel  <= f_cel;
                        end else begin
                            r_next <= r_next + 32'd1;
                        end
                    end
                end
                S_MFIN: begin
                    r_writable <= 1'b1;
                    r_ok       <= 1'b1;
                    r_state    <= S_DONE;
                    if (r_count == '0) begin
                        r_rp <= '0;
                        r_wp <= '0;
                    end else begin
                        r_rp <= r_max_slot;
                        r_wp <= (r_count < wlrs_pkg::CNT_W'(wlrs_pkg::SLOTS))
                                ? wlrs_pkg::next_slot(r_max_slot) : r_min_slot;
                    end
                end
                S_WR: begin
                    r_bi <= r_bi + BW'(1);
                    if (r_bi < BW'(wlrs_pkg::SUM_BYTES)) begin
                        r_sum <= {r_sum[5:0], 2'b00} + ram_wdata;
                    end else begin
                        r_slot_vld[r_wp] <= 1'b1;
                        r_rp    <= r_wp;
                        r_wp    <= wlrs_pkg::next_slot(r_wp);
                        r_next  <= r_wseq + 32'd1;
                        r_ok    <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = (r_state == S_DONE);
    assign o_done_ok         = r_ok;
    assign o_record_valid    = r_loaded;
    assign o_cur_temp        = r_temp;
    assign o_cur_temp_min    = r_tmin;
    assign o_cur_temp_max    = r_tmax;
    assign o_cur_off_timeout = r_off;
    assign o_cur_celsius     = |r_cel;
    assign o_record_id       = (r_next == 32'd0) ? 32'd1 : r_next;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");
    a_strobe_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy && !o_valid)
        else $error("result strobe longer than one cycle");
    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_writable)
        else $error("record write before mount");

endmodule
`default_nettype wire

FILE: bench/wear_leveled_record_store_core_tb.sv
`default_nettype none
module wear_leveled_record_store_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] temp;
        logic [15:0] lo_temp;
        logic [15:0] hi_temp;
        logic [7:0]  off_minutes;
        logic        celsius;
        logic        write_back;
    } t_cmd;

    typedef struct packed {
        logic        done_ok;
        logic        record_valid;
        logic [15:0] temp;
        logic [15:0] lo_temp;
        logic [15:0] hi_temp;
        logic [7:0]  off_minutes;
        logic        celsius;
        logic [31:0] record_id;
    } t_status;

    localparam logic [2:0] ACT_BAD6 = 3'd6;
    localparam logic [2:0] ACT_BAD7 = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_action;
    logic [15:0] i_new_temp;
    logic [15:0] i_new_temp_min;
    logic [15:0] i_new_temp_max;
    logic [7:0]  i_new_off_timeout;
    logic        i_new_celsius;
    logic        i_write_back;
    logic        o_valid;
    logic        o_done_ok;
    logic        o_record_valid;
    logic [15:0] o_cur_temp;
    logic [15:0] o_cur_temp_min;
    logic [15:0] o_cur_temp_max;
    logic [7:0]  o_cur_off_timeout;
    logic        o_cur_celsius;
    logic [31:0] o_record_id;

    wear_leveled_record_store_core dut (.*);

    // shadow of the store
    logic [7:0]  ring_mem [wlrs_pkg::STORE_BYTES];
    logic [15:0] wc_temp, wc_min, wc_max;
    logic [7:0]  wc_off, wc_cels;
    int unsigned rd_ptr, wr_ptr;
    logic [31:0] seq_next;
    logic        ring_open, last_load_ok;

    t_cmd      pending_cmds[$];
    t_status   expected_status[$];
    int        mismatches;
    logic      drain_hold;
    logic      quiet_mode;

    function automatic logic [7:0] chk_step(logic [7:0] s, logic [7:0] b);
        return (s << 2) + b;
    endfunction

    function automatic void store_defaults();
        wc_temp = wlrs_pkg::DEF_SET; wc_min = wlrs_pkg::DEF_MIN; wc_max = wlrs_pkg::DEF_MAX;
        wc_off = 8'd0; wc_cels = 8'd1;
    endfunction

    function automatic logic slot_read(int unsigned a, output logic [31:0] sq);
        logic [7:0] b [16];
        logic [7:0] s;
        s = 8'd0;
        for (int i = 0; i < 16; i++)
            b[i] = (a + i < wlrs_pkg::STORE_BYTES) ? ring_mem[a + i] : 8'hFF;
        for (int i = 0; i < 12; i++) s = chk_step(s, b[i]);
        s = s + 8'd1;
        sq = 32'd0;
        if (s != b[15]) return 1'b0;
        sq = {b[3], b[2], b[1], b[0]};
        wc_min = {b[5], b[4]};
        wc_max = {b[7], b[6]};
        wc_temp = {b[9], b[8]};
        wc_off = b[10];
        wc_cels = b[11];
        return 1'b1;
    endfunction

    function automatic int unsigned slot_after(int unsigned a);
        int unsigned n;
        n = a + wlrs_pkg::RECORD_BYTES;
        if (n + wlrs_pkg::RECORD_BYTES > wlrs_pkg::STORE_BYTES) n = 0;
        return n;
    endfunction

    function automatic logic record_append();
        logic [7:0] p [12];
        logic [7:0] s;
        if (!ring_open) return 1'b0;
        if (seq_next == 0) seq_next = 32'd1;
        p = '{seq_next[7:0], seq_next[15:8], seq_next[23:16], seq_next[31:24],
              wc_min[7:0], wc_min[15:8], wc_max[7:0], wc_max[15:8],
              wc_temp[7:0], wc_temp[15:8], wc_off, wc_cels};
        s = 8'd0;
        for (int i = 0; i < 12; i++) begin
            ring_mem[wr_ptr + i] = p[i];
            s = chk_step(s, p[i]);
        end
        ring_mem[wr_ptr + wlrs_pkg::RECORD_BYTES - 1] = s + 8'd1;
        rd_ptr = wr_ptr;
        wr_ptr = slot_after(wr_ptr);
        seq_next = seq_next + 32'd1;
        return 1'b1;
    endfunction

    function automatic void ring_mount();
        int unsigned cnt, a;
        logic [31:0] sq, lo_id, hi_id;
        int unsigned lo_a, hi_a;
        cnt = 0; lo_id = 32'hFFFF_FFFF; hi_id = 0; lo_a = 0; hi_a = 0;
        store_defaults();
        seq_next = 0;
        for (int i = 0; i < wlrs_pkg::SLOTS; i++) begin
            a = i * wlrs_pkg::RECORD_BYTES;
            if (!slot_read(a, sq)) break;
            cnt++;
            if (lo_id > sq) begin lo_id = sq; lo_a = a; end
            if (hi_id < sq) begin hi_id = sq; hi_a = a; end
        end
        ring_open = 1'b1;
        if (cnt == 0) begin
            rd_ptr = 0; wr_ptr = 0;
        end else begin
            rd_ptr = hi_a;
            wr_ptr = (cnt < wlrs_pkg::SLOTS) ? slot_after(hi_a) : lo_a;
        end
    endfunction

    function automatic logic ring_load();
        logic [31:0] sq;
        logic ok;
        ok = slot_read(rd_ptr, sq);
        last_load_ok = ok;
        seq_next = (ok ? sq : seq_next) + 32'd1;
        if (ok) begin
            if (wc_min >= wc_max) store_defaults();
            if (wc_temp > wc_max || wc_temp < wc_min) wc_temp = wlrs_pkg::DEF_SET;
            if (wc_off > wlrs_pkg::MAX_OFF) wc_off = 8'd0;
        end
        return ok;
    endfunction

    function automatic t_status predict_status(t_cmd c);
        t_status r;
        logic ok;
        logic [7:0] off;
        ok = 1'b0;
        case (c.action)
            wlrs_pkg::ACT_MOUNT: begin ring_mount(); ok = 1'b1; end
            wlrs_pkg::ACT_LOAD: ok = ring_load();
            wlrs_pkg::ACT_SAVE_TEMP: begin
                if (c.temp == wc_temp) ok = 1'b1;
                else begin wc_temp = c.temp; ok = record_append(); end
            end
            wlrs_pkg::ACT_SAVE_SET: begin
                off = (c.off_minutes > wlrs_pkg::MAX_OFF) ? 8'd0 : c.off_minutes;
                wc_off = off;
                wc_cels = {7'd0, c.celsius};
                ok = record_append();
            end
            wlrs_pkg::ACT_SAVE_CAL: begin
                wc_max = c.hi_temp; wc_min = c.lo_temp;
                ok = record_append();
            end
            wlrs_pkg::ACT_DEFAULTS: begin
                store_defaults();
                ok = c.write_back ? record_append() : 1'b1;
            end
            default: ok = 1'b0;
        endcase
        r.done_ok = ok;
        r.record_valid = last_load_ok;
        r.temp = wc_temp;
        r.lo_temp = wc_min;
        r.hi_temp = wc_max;
        r.off_minutes = wc_off;
        r.celsius = (wc_cels != 0);
        r.record_id = (seq_next == 0) ? 32'd1 : seq_next;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic t_cmd rand_cmd(logic [2:0] act);
        t_cmd c;
        c.action = act;
        c.temp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(500, 950));
        c.lo_temp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 700));
        c.hi_temp = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(600, 1200));
        c.off_minutes = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
        c.celsius = 1'($urandom);
        c.write_back = 1'($urandom);
        return c;
    endfunction

    function automatic logic [2:0] rand_action();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) return wlrs_pkg::ACT_MOUNT;
        if (r < 14) return wlrs_pkg::ACT_LOAD;
        if (r < 40) return wlrs_pkg::ACT_SAVE_TEMP;
        if (r < 62) return wlrs_pkg::ACT_SAVE_SET;
        if (r < 84) return wlrs_pkg::ACT_SAVE_CAL;
        if (r < 97) return wlrs_pkg::ACT_DEFAULTS;
        return r[0] ? ACT_BAD6 : ACT_BAD7;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else begin
            if (start && pending_cmds.size() > 0) begin
                expected_status.push_back(predict_status(pending_cmds.pop_front()));
            end
            if (pending_cmds.size() > 0 && !(drain_hold && expected_status.size() > 0)
                && (quiet_mode || $urandom_range(0, 99) >= 15)) begin
                start <= 1'b1;
                i_action <= pending_cmds[0].action;
                i_new_temp <= pending_cmds[0].temp;
                i_new_temp_min <= pending_cmds[0].lo_temp;
                i_new_temp_max <= pending_cmds[0].hi_temp;
                i_new_off_timeout <= pending_cmds[0].off_minutes;
                i_new_celsius <= pending_cmds[0].celsius;
                i_write_back <= pending_cmds[0].write_back;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_status w;
        if (i_rst_n && o_valid) begin
            if (expected_status.size() == 0) begin
                report_mismatch("unexpected result", 32'd0, 32'd0);
            end else begin
                w = expected_status.pop_front();
                if (o_done_ok !== w.done_ok) report_mismatch("done_ok", o_done_ok, w.done_ok);
                if (o_record_valid !== w.record_valid)
                    report_mismatch("record_valid", o_record_valid, w.record_valid);
                if (o_cur_temp !== w.temp) report_mismatch("cur_temp", o_cur_temp, w.temp);
                if (o_cur_temp_min !== w.lo_temp)
                    report_mismatch("cur_temp_min", o_cur_temp_min, w.lo_temp);
                if (o_cur_temp_max !== w.hi_temp)
                    report_mismatch("cur_temp_max", o_cur_temp_max, w.hi_temp);
                if (o_cur_off_timeout !== w.off_minutes)
                    report_mismatch("cur_off_timeout", o_cur_off_timeout, w.off_minutes);
                if (o_cur_celsius !== w.celsius)
                    report_mismatch("cur_celsius", o_cur_celsius, w.celsius);
                if (o_record_id !== w.record_id)
                    report_mismatch("record_id", o_record_id, w.record_id);
            end
        end
    end

    initial begin
        #60ms;
        $display("wear_leveled_record_store_core test failed");
        $finish;
    end

    initial begin
        t_cmd c;
        mismatches = 0;
        for (int i = 0; i < wlrs_pkg::STORE_BYTES; i++) ring_mem[i] = 8'hFF;
        store_defaults();
        rd_ptr = 0; wr_ptr = 0; seq_next = 0; ring_open = 0; last_load_ok = 0;
        drain_hold = 1'b0; quiet_mode = 1'b0;
        start = 1'b0; i_rst_n = 1'b0;
        i_action = 3'd0; i_new_temp = '0; i_new_temp_min = '0; i_new_temp_max = '0;
        i_new_off_timeout = '0; i_new_celsius = 1'b0; i_write_back = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: saves before mount, load of empty store, bad codes, extremes
        c = rand_cmd(wlrs_pkg::ACT_SAVE_TEMP); c.temp = 16'd100; pending_cmds.push_back(c);
        c = rand_cmd(wlrs_pkg::ACT_SAVE_SET); pending_cmds.push_back(c);
        pending_cmds.push_back(rand_cmd(wlrs_pkg::ACT_LOAD));
        pending_cmds.push_back(rand_cmd(ACT_BAD6));
        pending_cmds.push_back(rand_cmd(ACT_BAD7));
        pending_cmds.push_back(rand_cmd(wlrs_pkg::ACT_MOUNT));
        c = rand_cmd(wlrs_pkg::ACT_SAVE_TEMP); c.temp = 16'hFFFF; pending_cmds.push_back(c);
        c = rand_cmd(wlrs_pkg::ACT_SAVE_TEMP); c.temp = 16'hFFFF; pending_cmds.push_back(c);
        c = rand_cmd(wlrs_pkg::ACT_SAVE_TEMP); c.temp = 16'h0000; pending_cmds.push_back(c);
        c = rand_cmd(wlrs_pkg::ACT_SAVE_SET); c.off_minutes = 8'hFF; c.celsius = 0;
        pending_cmds.push_back(c);
        c = rand_cmd(wlrs_pkg::ACT_SAVE_SET); c.off_minutes = 8'd30; c.celsius = 1;
        pending_cmds.push_back(c);
        c = rand_cmd(wlrs_pkg::ACT_SAVE_SET); c.off_minutes = 8'd31; pending_cmds.push_back(c);
        c = rand_cmd(wlrs_pkg::ACT_SAVE_CAL); c.lo_temp = 16'hFFFF; c.hi_temp = 16'h0000;
        pending_cmds.push_back(c);
        pending_cmds.push_back(rand_cmd(wlrs_pkg::ACT_LOAD));
        c = rand_cmd(wlrs_pkg::ACT_SAVE_CAL); c.lo_temp = 16'd0; c.hi_temp = 16'hFFFF;
        pending_cmds.push_back(c);
        pending_cmds.push_back(rand_cmd(wlrs_pkg::ACT_LOAD));
        c = rand_cmd(wlrs_pkg::ACT_DEFAULTS); c.write_back = 0; pending_cmds.push_back(c);
        c = rand_cmd(wlrs_pkg::ACT_DEFAULTS); c.write_back = 1; pending_cmds.push_back(c);
        pending_cmds.push_back(rand_cmd(wlrs_pkg::ACT_MOUNT));
        pending_cmds.push_back(rand_cmd(wlrs_pkg::ACT_LOAD));

        // let the queue drain before the random part
        drain_hold = 1'b1;
        wait (pending_cmds.size() == 0 && expected_status.size() == 0);
        @(posedge i_clk);
        drain_hold = 1'b0;

        // enough saves to wrap the ring several times, mounts over a full ring
        for (int i = 0; i < 520; i++) begin
            if (i == 150) quiet_mode = 1'b1;
            if (i == 230) quiet_mode = 1'b0;
            pending_cmds.push_back(rand_cmd(rand_action()));
            while (pending_cmds.size() > 4) @(posedge i_clk);
        end
        wait (pending_cmds.size() == 0 && expected_status.size() == 0);
        repeat (950) @(posedge i_clk);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("wear_leveled_record_store_core test passed");
        else
            $display("wear_leveled_record_store_core test failed");
        $finish;
    end
endmodule
`default_nettype wire
